// File: rtl/core/binary_to_decimal_text_macros.svh
// Assertion helpers for the decimal text block; clock and reset are the module's own.
`ifndef BINARY_TO_DECIMAL_TEXT_MACROS_SVH
`define BINARY_TO_DECIMAL_TEXT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B2DT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b2dt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define B2DT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("b2dt: next-cycle check failed");

`endif

// File: rtl/core/b2dt_pkg.sv
`default_nettype none

package b2dt_pkg;

   localparam int unsigned VALUE_W   = 16;
   localparam int unsigned DIGIT_CNT = 5;
   localparam int unsigned BCD_W     = 4 * DIGIT_CNT;
   localparam int unsigned SHIFT_W   = $clog2(VALUE_W);
   localparam int unsigned LEFT_W    = $clog2(DIGIT_CNT);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      E_IDLE,
      E_SIGN,
      E_SKIP,
      E_DIGIT,
      E_TERM
   } emit_state_type;

   typedef struct packed {
      logic done;
      logic minus;
   } conv_status_type;

endpackage

`default_nettype wire

// File: rtl/core/b2dt_dabble.sv
`default_nettype none

module b2dt_dabble (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [b2dt_pkg::VALUE_W-1:0]  value,
   output logic                               running,
   output logic                               done,
   output logic      [b2dt_pkg::BCD_W-1:0]    bcd
);
   import b2dt_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;
   logic [SHIFT_W-1:0] cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   // add three to every digit of five or more, then shift one bit in
   always_comb begin
      for (int i = 0; i < DIGIT_CNT; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SHIFT_W'(VALUE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign running = run_ff;
   assign done    = done_ff;
   assign bcd     = bcd_ff;

endmodule

`default_nettype wire

// File: rtl/core/b2dt_emit.sv
`default_nettype none

module b2dt_emit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire b2dt_pkg::conv_status_type         status,
   input  wire logic [b2dt_pkg::BCD_W-1:0]        bcd,
   output logic                                   idle,
   output logic                                   strobe,
   output logic      [7:0]                        text_char,
   output logic                                   last_char
);
   import b2dt_pkg::*;

   emit_state_type    state_ff, state_in;
   logic [BCD_W-1:0]  digit_ff, digit_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [3:0]        top_digit;

   assign top_digit = digit_ff[BCD_W-1 -: 4];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      left_ff  <= left_in;
   end

   always_comb begin
      state_in  = state_ff;
      digit_in  = digit_ff;
      left_in   = left_ff;
      strobe    = 1'b0;
      text_char = CH_CR;
      last_char = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (status.done) begin
               digit_in = bcd;
               left_in  = LEFT_W'(DIGIT_CNT - 1);
               state_in = status.minus ? E_SIGN : E_SKIP;
            end
         end
         E_SIGN: begin
            strobe    = 1'b1;
            text_char = CH_MINUS;
            state_in  = E_SKIP;
         end
         // drop leading zeros, always keep the units digit
         E_SKIP: begin
            if (top_digit == 4'd0 && left_ff != '0) begin
               digit_in = {digit_ff[BCD_W-5:0], 4'd0};
               left_in  = left_ff - 1'b1;
            end else begin
               state_in = E_DIGIT;
            end
         end
         E_DIGIT: begin
            strobe    = 1'b1;
            text_char = CH_ZERO + {4'd0, top_digit};
            digit_in  = {digit_ff[BCD_W-5:0], 4'd0};
            if (left_ff == '0) begin
               state_in = E_TERM;
            end else begin
               left_in = left_ff - 1'b1;
            end
         end
         E_TERM: begin
            strobe    = 1'b1;
            text_char = CH_CR;
            last_char = 1'b1;
            state_in  = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == E_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/binary_to_decimal_text.sv
// binary_to_decimal_text: prints a 16-bit number as ASCII decimal text.
// Input: raise start with req_raw_value and req_signed_mode; the item is
// taken at a clock edge where start is high and busy is low. busy stays high
// from the cycle after that edge until the last character has gone out.
// Output: one character per beat on rsp_text_char, marked by a one-cycle
// rsp_strobe; the receiver cannot stall, every beat is taken as it comes.
// Order: optional '-', one to five digits without leading zeros, then a
// carriage return with rsp_last_char high.
// Flow: a bit-serial shift-add-3 converter works through the magnitude,
// then hands the digits to the character sequencer, which emits the
// optional sign, skips suppressed leading zeros one at a time until it
// finds the first digit, then emits the digits and the carriage return.
// The next item is taken only after that carriage return has gone out.
// Reset: synchronous, active high; clears the converter and sequencer, so
// any run in flight is abandoned and no further beats appear.
`default_nettype none

`include "binary_to_decimal_text_macros.svh"

module binary_to_decimal_text (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [b2dt_pkg::VALUE_W-1:0]      req_raw_value,
   input  wire logic                              req_signed_mode,
   output logic                                   rsp_strobe,
   output logic      [7:0]                        rsp_text_char,
   output logic                                   rsp_last_char
);
   import b2dt_pkg::*;

   logic               accept;
   logic               negative;
   logic [VALUE_W-1:0] magnitude;
   logic               minus_ff;
   logic               conv_running;
   logic               conv_done;
   logic [BCD_W-1:0]   conv_bcd;
   logic               emit_idle;
   conv_status_type    status;

   assign accept    = start && !busy;
   assign negative  = req_signed_mode && req_raw_value[VALUE_W-1];
   assign magnitude = negative ? (~req_raw_value) + VALUE_W'(1) : req_raw_value;

   always_ff @(posedge clock) begin
      if (accept) begin
         minus_ff <= negative;
      end
   end

   b2dt_dabble u_dabble (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .value   (magnitude),
      .running (conv_running),
      .done    (conv_done),
      .bcd     (conv_bcd)
   );

   assign status.done  = conv_done;
   assign status.minus = minus_ff;

   b2dt_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .bcd       (conv_bcd),
      .idle      (emit_idle),
      .strobe    (rsp_strobe),
      .text_char (rsp_text_char),
      .last_char (rsp_last_char)
   );

   assign busy = conv_running || conv_done || !emit_idle;

   `B2DT_ASSERT_SAME(a_strobe_while_busy, rsp_strobe, busy)
   `B2DT_ASSERT_NEXT(a_accept_sets_busy, accept, busy && !rsp_strobe)
   `B2DT_ASSERT_SAME(a_last_is_cr, rsp_strobe && rsp_last_char, rsp_text_char == CH_CR)
   `B2DT_ASSERT_SAME(a_done_finds_idle, conv_done, emit_idle && !conv_running)

endmodule

`default_nettype wire

// File: sim/binary_to_decimal_text_tb.sv
`default_nettype none

module binary_to_decimal_text_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b2dt_pkg::*;

   localparam int RANDOM_ITEMS = 80;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 60000;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               sgn;
      int                 gap;
   } number_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [VALUE_W-1:0] req_raw_value = '0;
   logic               req_signed_mode = 1'b0;
   logic               rsp_strobe;
   logic [7:0]         rsp_text_char;
   logic               rsp_last_char;

   number_item_type number_fifo [$];
   char_beat_type   text_expected [$];
   number_item_type cur_item;
   bit              have_item = 1'b0;
   int              gap_left = 0;
   int              items_total = 0;
   int              items_taken = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   binary_to_decimal_text DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_raw_value   (req_raw_value),
      .req_signed_mode (req_signed_mode),
      .rsp_strobe      (rsp_strobe),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void decimal_text_of(input logic [VALUE_W-1:0] raw, input logic sgn);
      int unsigned weight [4] = '{10000, 1000, 100, 10};
      int unsigned digit [5];
      int unsigned rest;
      int unsigned lead;
      logic [VALUE_W-1:0] mag;
      mag = raw;
      if (sgn && raw[VALUE_W-1]) begin
         text_expected.push_back(char_beat_type'{CH_MINUS, 1'b0});
         mag = -raw;
      end
      rest = mag;
      for (int i = 0; i < 4; i++) begin
         digit[i] = 0;
         while (rest >= weight[i]) begin
            rest = rest - weight[i];
            digit[i]++;
         end
      end
      digit[4] = rest;
      lead = 0;
      while (lead < 4 && digit[lead] == 0) lead++;
      for (int i = lead; i < 5; i++) begin
         text_expected.push_back(char_beat_type'{CH_ZERO + 8'(digit[i]), 1'b0});
      end
      text_expected.push_back(char_beat_type'{CH_CR, 1'b1});
   endfunction

   function automatic void queue_number(input logic [VALUE_W-1:0] value, input logic sgn,
                                        input int gap);
      number_item_type item;
      item.value = value;
      item.sgn   = sgn;
      item.gap   = gap;
      number_fifo.push_back(item);
      items_total++;
   endfunction

   // driver: hold start until the beat is taken, then idle for the next item's gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            decimal_text_of(req_raw_value, req_signed_mode);
            items_taken++;
            have_item = 1'b0;
         end
         if (!have_item && number_fifo.size() != 0) begin
            cur_item  = number_fifo.pop_front();
            have_item = 1'b1;
            gap_left  = cur_item.gap;
         end
         if (have_item && gap_left == 0) begin
            start           <= 1'b1;
            req_raw_value   <= cur_item.value;
            req_signed_mode <= cur_item.sgn;
         end else begin
            start <= 1'b0;
            if (have_item) gap_left--;
         end
      end
   end

   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_strobe) begin
         if (text_expected.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual char %h last %b",
                     $time, rsp_text_char, rsp_last_char);
            error_count++;
         end else begin
            want = text_expected.pop_front();
            if (rsp_text_char !== want.ch) begin
               $display("%0t: text_char expected %h actual %h", $time, want.ch, rsp_text_char);
               error_count++;
            end
            if (rsp_last_char !== want.last) begin
               $display("%0t: last_char expected %b actual %b", $time, want.last,
                        rsp_last_char);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[binary_to_decimal_text] ERROR");
         $finish;
      end
   end

   initial begin
      int pow10 [5] = '{1, 10, 100, 1000, 10000};
      logic [VALUE_W-1:0] value;
      logic sgn;
      int gap;
      bit burst;

      queue_number(16'd0,     1'b0, 0);
      queue_number(16'd0,     1'b1, 0);
      queue_number(16'hFFFF,  1'b0, 3);
      queue_number(16'hFFFF,  1'b1, 0);
      queue_number(16'h8000,  1'b1, 1);
      queue_number(16'h8000,  1'b0, 0);
      queue_number(16'h7FFF,  1'b1, 5);
      queue_number(16'h7FFF,  1'b0, 0);
      queue_number(16'h8001,  1'b1, 0);
      queue_number(16'd9,     1'b0, 2);
      queue_number(16'd10,    1'b1, 0);
      queue_number(16'd99,    1'b0, 0);
      queue_number(16'd100,   1'b0, 19);
      queue_number(16'd999,   1'b1, 0);
      queue_number(16'd1000,  1'b0, 0);
      queue_number(16'd9999,  1'b0, 7);
      queue_number(16'd10000, 1'b1, 0);
      queue_number(16'd10001, 1'b0, 0);
      queue_number(16'hFFF6,  1'b1, 0);
      queue_number(16'hD8F0,  1'b1, 4);
      queue_number(16'd1,     1'b1, 0);
      queue_number(16'h5555,  1'b0, 0);
      queue_number(16'hAAAA,  1'b0, 1);

      burst = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 8 == 0) burst = ($urandom_range(0, 2) == 0);
         sgn = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: value = VALUE_W'($urandom);
            1: value = VALUE_W'($urandom_range(0, pow10[$urandom_range(1, 4)]));
            2: value = VALUE_W'(pow10[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1);
            default: begin
               value = 16'h8000 | VALUE_W'($urandom);
               sgn   = 1'b1;
            end
         endcase
         gap = burst ? 0 : int'($urandom_range(0, 19));
         queue_number(value, sgn, gap);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (items_taken != items_total || text_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("[binary_to_decimal_text] OK");
      end else begin
         $display("[binary_to_decimal_text] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
